FILE: src/ctb_pkg.sv
// ----------------------------------------------------------------------------
// ctb_pkg
// shared types and codes for the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

    // command codes carried on the command port
    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_code_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_DRAIN = 2'd2,
        ST_FLUSH = 2'd3
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // arm the slot on the slot port
        logic drop;       // free the slot on the slot port
        logic scan_read;  // read the slot under the scan index and advance
        logic flush;      // release the held report as the last one
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index sits on the highest slot
    } ctl_stat_t;

endpackage

FILE: src/ctb_ram.sv
// ----------------------------------------------------------------------------
// ctb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ctb_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/ctb_ctrl.sv
// ----------------------------------------------------------------------------
// ctb_ctrl
// command decode and tick sequencing for the countdown timer bank
// ----------------------------------------------------------------------------
module ctb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [1:0]           command,
    input  ctb_pkg::ctl_stat_t   stat,
    output ctb_pkg::ctl_cmd_t    cmd,
    output logic                 busy
);

    ctb_pkg::ctl_state_t state_reg;
    ctb_pkg::ctl_state_t state_next;
    ctb_pkg::cmd_code_t  code;
    logic                accept;

    assign code   = ctb_pkg::cmd_code_t'(command);
    assign accept = start && (state_reg == ctb_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                if (accept && (code == ctb_pkg::CMD_TICK))
                begin
                    state_next = ctb_pkg::ST_SCAN;
                end
            end
            ctb_pkg::ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ctb_pkg::ST_DRAIN;
                end
            end
            ctb_pkg::ST_DRAIN:
            begin
                state_next = ctb_pkg::ST_FLUSH;
            end
            ctb_pkg::ST_FLUSH:
            begin
                state_next = ctb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        busy      = 1'b1;
        case (state_reg)
            ctb_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = accept && (code == ctb_pkg::CMD_ADD);
                cmd.drop = accept && (code == ctb_pkg::CMD_DELETE);
            end
            ctb_pkg::ST_SCAN:
            begin
                cmd.scan_read = 1'b1;
            end
            ctb_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            ctb_pkg::ST_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: src/ctb_datapath.sv
// ----------------------------------------------------------------------------
// ctb_datapath
// slot storage, active flags, count update and report staging
// ----------------------------------------------------------------------------
module ctb_datapath #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctb_pkg::ctl_cmd_t    cmd,
    output ctb_pkg::ctl_stat_t   stat,
    input  logic [3:0]           slot,
    input  logic [31:0]          start_count,
    input  logic                 auto_reload,
    input  logic                 notify,
    output logic                 result_valid,
    output logic [3:0]           expired_slot,
    output logic                 last
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W = 2 * COUNT_BITS + 2;

    logic [SLOTS-1:0]      active_reg, active_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  proc_valid_reg, proc_valid_next;
    logic [IDX_W-1:0]      proc_idx_reg, proc_idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  res_valid_reg, res_valid_next;
    logic [IDX_W-1:0]      res_idx_reg, res_idx_next;
    logic                  res_last_reg, res_last_next;

    logic                  slot_ok;
    logic [IDX_W-1:0]      add_idx;
    logic [COUNT_BITS-1:0] start_ext;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [COUNT_BITS-1:0] cur_rem;
    logic [COUNT_BITS-1:0] cur_reload;
    logic                  cur_report_en;
    logic                  cur_reload_en;
    logic                  proc_active;
    logic                  cur_zero;
    logic                  hit;
    logic [COUNT_BITS-1:0] new_rem;

    assign slot_ok   = (32'(slot) < SLOTS);
    assign add_idx   = IDX_W'(slot);
    assign start_ext = COUNT_BITS'(start_count);

    assign stat.scan_last = (scan_idx_reg == IDX_W'(SLOTS - 1));

    // entry layout: reload flag, notify flag, reload count, current count
    assign cur_rem       = ram_rdata[COUNT_BITS-1:0];
    assign cur_reload    = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
    assign cur_report_en = ram_rdata[2*COUNT_BITS];
    assign cur_reload_en = ram_rdata[2*COUNT_BITS+1];

    assign proc_active = proc_valid_reg & active_reg[proc_idx_reg];
    assign cur_zero    = (cur_rem == '0);
    assign hit         = proc_active & cur_zero & cur_report_en;

    always_comb
    begin
        if (!cur_zero)
        begin
            new_rem = cur_rem - COUNT_BITS'(1);
        end
        else if (cur_reload_en)
        begin
            new_rem = cur_reload;
        end
        else
        begin
            new_rem = cur_rem;
        end
    end

    // ram write: arming has priority, write-back only during a scan
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = proc_idx_reg;
        ram_wdata = {cur_reload_en, cur_report_en, cur_reload, new_rem};
        if (cmd.load && slot_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = add_idx;
            ram_wdata = {auto_reload, notify, start_ext, start_ext};
        end
        else if (proc_active)
        begin
            ram_we = 1'b1;
        end
    end

    ctb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_read),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        active_next     = active_reg;
        scan_idx_next   = scan_idx_reg;
        proc_valid_next = cmd.scan_read;
        proc_idx_next   = scan_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        res_valid_next  = 1'b0;
        res_idx_next    = res_idx_reg;
        res_last_next   = res_last_reg;

        if (cmd.load && slot_ok)
        begin
            active_next[add_idx] = 1'b1;
        end
        if (cmd.drop && slot_ok)
        begin
            active_next[add_idx] = 1'b0;
        end

        if (cmd.scan_read)
        begin
            if (stat.scan_last)
            begin
                scan_idx_next = '0;
            end
            else
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
            end
        end

        // a new report pushes the held one out as not last
        if (hit)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_idx_next   = pend_idx_reg;
                res_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_idx_next   = proc_idx_reg;
        end

        if (cmd.flush && pend_valid_reg)
        begin
            res_valid_next  = 1'b1;
            res_idx_next    = pend_idx_reg;
            res_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            scan_idx_reg   <= '0;
            proc_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            scan_idx_reg   <= scan_idx_next;
            proc_valid_reg <= proc_valid_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_idx_reg <= proc_idx_next;
        pend_idx_reg <= pend_idx_next;
        res_idx_reg  <= res_idx_next;
        res_last_reg <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign expired_slot = 4'(res_idx_reg);
    assign last         = res_last_reg;

endmodule

FILE: src/countdown_timer_bank.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank
// bank of countdown timer slots with auto-reload and expiry reports
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Add and delete leave
// busy low, so the next item can follow at once. A tick keeps busy high
// while the single read port of the slot ram walks one slot per cycle, while
// the drain state finishes the highest slot and while the flush state
// releases the final report. Reports come out in ascending slot order, one
// per cycle at most, each on result_valid for exactly one cycle; the last
// report of a tick carries last = 1 and comes in the cycle busy falls.
// The receiver cannot hold reports off, so it must take every strobe.
// A tick with nothing to report gives no strobe at all. There is no
// clearing pass after reset: only the flags, scan index and state reset.
module countdown_timer_bank #(
    parameter int SLOTS      = 16,
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [3:0]  slot,
    input  logic [31:0] start_count,
    input  logic        auto_reload,
    input  logic        notify,
    output logic        result_valid,
    output logic [3:0]  expired_slot,
    output logic        last
);

    // command and status between sequencer and datapath
    ctb_pkg::ctl_cmd_t  ctl_cmd;
    ctb_pkg::ctl_stat_t ctl_stat;

    // sequencer: decodes commands and steps a tick through its phases
    ctb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (ctl_stat),
        .cmd     (ctl_cmd),
        .busy    (busy)
    );

    // datapath: slot ram, active flags, count update, one-deep report hold
    ctb_datapath #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (ctl_cmd),
        .stat         (ctl_stat),
        .slot         (slot),
        .start_count  (start_count),
        .auto_reload  (auto_reload),
        .notify       (notify),
        .result_valid (result_valid),
        .expired_slot (expired_slot),
        .last         (last)
    );

`ifndef NO_ASSERTIONS
    // add and delete finish in the cycle they are taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != ctb_pkg::CMD_TICK)) |=> !busy)
        else $error("busy raised by a non-tick item");

    // a report that is not the final one always comes while the tick runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final report outside a tick");

    // the final report closes the tick: nothing follows it directly
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("report right after the final one");
`endif

endmodule
